### src/attp_pkg.sv
// ----------------------------------------------------------------------------
// attp_pkg
// Shared widths, constants, register map and helpers for the attitude
// proportional torque datapath.
// ----------------------------------------------------------------------------
package attp_pkg;

	localparam int BW      = 16;     // input component, Q1.14
	localparam int PW      = 32;     // 16x16 product
	localparam int XW      = 33;     // cross term
	localparam int SQW     = 48;     // square root operand
	localparam int RW      = 24;     // square root result, unsigned Q2.22
	localparam int CW      = 44;     // CORDIC vector width
	localparam int AW      = 20;     // angle, 2^-16 rad
	localparam int EW      = 19;     // clamped error angle
	localparam int MW      = 36;     // angle times inertia
	localparam int SMW     = 37;     // weighted sum
	localparam int SW      = 54;     // sum times gain
	localparam int PPW     = 56;     // partial product of cosine scale
	localparam int TW      = 70;     // combined torque
	localparam int CFGW    = 16;     // register width
	localparam int TAB_LEN = 24;

	localparam logic signed [AW-1:0] ANG_PI = 20'sd205887;

	localparam logic [1:0] REG_INERTIA_X = 2'd0;
	localparam logic [1:0] REG_INERTIA_Y = 2'd1;
	localparam logic [1:0] REG_INERTIA_Z = 2'd2;
	localparam logic [1:0] REG_GAIN      = 2'd3;

	localparam logic [CFGW-1:0] CFG_RESET = 16'd256;

	typedef struct packed {
		logic [8:0][BW-1:0] b;
		logic [4:0][XW-1:0] c;
	} carry_t;

	// round(atan(2^-i) * 2^16)
	function automatic logic signed [AW-1:0] atan_entry(input int i);
		logic signed [AW-1:0] v;
		case (i)
			0:       v = 20'sd51472;
			1:       v = 20'sd30385;
			2:       v = 20'sd16055;
			3:       v = 20'sd8150;
			4:       v = 20'sd4091;
			5:       v = 20'sd2047;
			6:       v = 20'sd1024;
			7:       v = 20'sd512;
			8:       v = 20'sd256;
			9:       v = 20'sd128;
			10:      v = 20'sd64;
			11:      v = 20'sd32;
			12:      v = 20'sd16;
			13:      v = 20'sd8;
			14:      v = 20'sd4;
			15:      v = 20'sd2;
			16:      v = 20'sd1;
			default: v = 20'sd0;
		endcase
		return v;
	endfunction

	// component times in-plane length
	function automatic logic signed [CW-1:0] mul_br(input logic signed [BW-1:0] b,
			input logic [RW-1:0] r);
		logic signed [CW-1:0] a;
		logic signed [CW-1:0] rr;
		a  = CW'(b);
		rr = $signed({{(CW-RW){1'b0}}, r});
		return a * rr;
	endfunction

	// |b| * 256
	function automatic logic signed [CW-1:0] abs256(input logic signed [BW-1:0] b);
		logic signed [BW:0] e;
		e = (BW+1)'(b);
		if (e < 0) begin
			e = -e;
		end
		return $signed({{(CW-BW-9){1'b0}}, e, 8'h00});
	endfunction

	// cross term * 256
	function automatic logic signed [CW-1:0] c256(input logic signed [XW-1:0] c);
		logic signed [XW+7:0] e;
		e = $signed({c, 8'h00});
		return CW'(e);
	endfunction

endpackage

### src/attitude_p_torque.sv
// ----------------------------------------------------------------------------
// attitude_p_torque
// Proportional restoring torques for roll, pitch and yaw from a body
// attitude matrix.
// ----------------------------------------------------------------------------
// Accepts one attitude matrix per clock while in_stall is low and returns
// one torque triple per matrix, in order. The pipeline is three input and
// product stages, a 24-stage square root, one argument stage, the
// CORDIC_STEPS + 1 stage atan2 pipelines, a clamp stage and five torque
// multiply stages ending in the output register. While out_valid is high
// and out_stall is asserted the whole pipeline holds and in_stall is high.
// The user must write registers only while no request is in flight (unchecked).
module attitude_p_torque #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,

	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] bx_x,
	input  logic signed [15:0] bx_y,
	input  logic signed [15:0] bx_z,
	input  logic signed [15:0] by_x,
	input  logic signed [15:0] by_y,
	input  logic signed [15:0] by_z,
	input  logic signed [15:0] bz_x,
	input  logic signed [15:0] bz_y,
	input  logic signed [15:0] bz_z,

	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] torque_roll,
	output logic signed [31:0] torque_pitch,
	output logic signed [31:0] torque_yaw
);

	localparam int BW   = attp_pkg::BW;
	localparam int PW   = attp_pkg::PW;
	localparam int XW   = attp_pkg::XW;
	localparam int SQW  = attp_pkg::SQW;
	localparam int RW   = attp_pkg::RW;
	localparam int CW   = attp_pkg::CW;
	localparam int AW   = attp_pkg::AW;
	localparam int EW   = attp_pkg::EW;
	localparam int MW   = attp_pkg::MW;
	localparam int SMW  = attp_pkg::SMW;
	localparam int SW   = attp_pkg::SW;
	localparam int PPW  = attp_pkg::PPW;
	localparam int TW   = attp_pkg::TW;
	localparam int CFGW = attp_pkg::CFGW;
	localparam int HALF = RW / 2;

	localparam int CL        = CORDIC_STEPS + 1;
	localparam int LAT       = CORDIC_STEPS + 35;
	localparam int CLAMP_IDX = CORDIC_STEPS + 29;

	localparam logic [2:0] NEG1 = 3'b010;
	localparam logic [2:0] NEG2 = 3'b101;

	// ---------------- configuration ----------------
	logic [CFGW-1:0] inertia_x_q, inertia_y_q, inertia_z_q, gain_q;
	logic            cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inertia_x_q <= attp_pkg::CFG_RESET;
			inertia_y_q <= attp_pkg::CFG_RESET;
			inertia_z_q <= attp_pkg::CFG_RESET;
			gain_q      <= attp_pkg::CFG_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				attp_pkg::REG_INERTIA_X: inertia_x_q <= pwdata[CFGW-1:0];
				attp_pkg::REG_INERTIA_Y: inertia_y_q <= pwdata[CFGW-1:0];
				attp_pkg::REG_INERTIA_Z: inertia_z_q <= pwdata[CFGW-1:0];
				attp_pkg::REG_GAIN:      gain_q      <= pwdata[CFGW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			attp_pkg::REG_INERTIA_X: prdata = {16'h0, inertia_x_q};
			attp_pkg::REG_INERTIA_Y: prdata = {16'h0, inertia_y_q};
			attp_pkg::REG_INERTIA_Z: prdata = {16'h0, inertia_z_q};
			attp_pkg::REG_GAIN:      prdata = {16'h0, gain_q};
			default:                 prdata = '0;
		endcase
	end

	// ---------------- pipeline control ----------------
	logic           en;
	logic [LAT-1:0] vld_q;

	assign out_valid = vld_q[LAT-1];
	assign en        = !vld_q[LAT-1] || !out_stall;
	assign in_stall  = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	// ---------------- s1: input ----------------
	logic signed [BW-1:0] b_s1 [9];

	always_ff @(posedge clk) begin
		if (en) begin
			b_s1[0] <= bx_x; b_s1[1] <= bx_y; b_s1[2] <= bx_z;
			b_s1[3] <= by_x; b_s1[4] <= by_y; b_s1[5] <= by_z;
			b_s1[6] <= bz_x; b_s1[7] <= bz_y; b_s1[8] <= bz_z;
		end
	end

	// ---------------- s2: products ----------------
	logic signed [BW-1:0] b_s2  [9];
	logic signed [PW-1:0] sq_s2 [7];
	logic signed [PW-1:0] pr_s2 [10];

	always_ff @(posedge clk) begin
		if (en) begin
			b_s2     <= b_s1;
			sq_s2[0] <= b_s1[0] * b_s1[0];
			sq_s2[1] <= b_s1[1] * b_s1[1];
			sq_s2[2] <= b_s1[3] * b_s1[3];
			sq_s2[3] <= b_s1[4] * b_s1[4];
			sq_s2[4] <= b_s1[6] * b_s1[6];
			sq_s2[5] <= b_s1[7] * b_s1[7];
			sq_s2[6] <= b_s1[8] * b_s1[8];
			pr_s2[0] <= b_s1[4] * b_s1[0];
			pr_s2[1] <= b_s1[3] * b_s1[1];
			pr_s2[2] <= b_s1[7] * b_s1[0];
			pr_s2[3] <= b_s1[6] * b_s1[1];
			pr_s2[4] <= b_s1[6] * b_s1[4];
			pr_s2[5] <= b_s1[7] * b_s1[3];
			pr_s2[6] <= b_s1[1] * b_s1[8];
			pr_s2[7] <= b_s1[2] * b_s1[7];
			pr_s2[8] <= b_s1[4] * b_s1[8];
			pr_s2[9] <= b_s1[5] * b_s1[7];
		end
	end

	// ---------------- s3: sums and cross terms ----------------
	logic [SQW-1:0]   sqv_s3 [4];
	attp_pkg::carry_t car_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			sqv_s3[0] <= {$unsigned(sq_s2[0]) + $unsigned(sq_s2[1]), 16'h0};
			sqv_s3[1] <= {$unsigned(sq_s2[2]) + $unsigned(sq_s2[3]), 16'h0};
			sqv_s3[2] <= {$unsigned(sq_s2[5]) + $unsigned(sq_s2[6]), 16'h0};
			sqv_s3[3] <= {$unsigned(sq_s2[4]) + $unsigned(sq_s2[5]), 16'h0};
			for (int i = 0; i < 9; i++) begin
				car_s3.b[i] <= b_s2[i];
			end
			for (int i = 0; i < 5; i++) begin
				car_s3.c[i] <= XW'(pr_s2[2*i]) - XW'(pr_s2[2*i+1]);
			end
		end
	end

	// ---------------- square roots ----------------
	logic [RW-1:0]    root [4];
	attp_pkg::carry_t car_dly_q [RW];

	genvar g;
	generate
		for (g = 0; g < 4; g++) begin : g_sqrt
			attp_sqrt u_sqrt (
				.clk  (clk),
				.en   (en),
				.v_in (sqv_s3[g]),
				.root (root[g])
			);
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (en) begin
			car_dly_q[0] <= car_s3;
			for (int i = 1; i < RW; i++) begin
				car_dly_q[i] <= car_dly_q[i-1];
			end
		end
	end

	// ---------------- s4: atan2 arguments ----------------
	logic signed [CW-1:0] ay_c [9];
	logic signed [CW-1:0] ax_c [9];
	logic [RW-1:0]        sc_c [3];
	logic signed [CW-1:0] ay_s4 [9];
	logic signed [CW-1:0] ax_s4 [9];
	logic [RW-1:0]        sc_s4 [3];

	always_comb begin
		logic signed [BW-1:0] bb [9];
		logic signed [XW-1:0] cc [5];
		logic signed [CW-1:0] ab22;
		for (int i = 0; i < 9; i++) begin
			bb[i] = $signed(car_dly_q[RW-1].b[i]);
		end
		for (int i = 0; i < 5; i++) begin
			cc[i] = $signed(car_dly_q[RW-1].c[i]);
		end
		ab22 = attp_pkg::abs256(bb[8]);

		ay_c[0] = $signed({{(CW-RW){1'b0}}, root[0]});
		ax_c[0] = attp_pkg::abs256(bb[2]);
		ay_c[1] = attp_pkg::mul_br(bb[5], root[0]);
		ax_c[1] = attp_pkg::c256(cc[0]);
		ay_c[2] = attp_pkg::c256(cc[1]);
		ax_c[2] = attp_pkg::mul_br(bb[8], root[0]);

		ay_c[3] = $signed({{(CW-RW){1'b0}}, root[1]});
		ax_c[3] = attp_pkg::abs256(bb[5]);
		ay_c[4] = attp_pkg::mul_br(bb[2], root[1]);
		ax_c[4] = attp_pkg::c256(cc[0]);
		ay_c[5] = attp_pkg::c256(cc[2]);
		ax_c[5] = attp_pkg::mul_br(bb[8], root[1]);

		ay_c[6] = ab22;
		ax_c[6] = $signed({{(CW-RW){1'b0}}, root[3]});
		ay_c[7] = attp_pkg::c256(cc[3]);
		ax_c[7] = attp_pkg::mul_br(bb[0], root[2]);
		ay_c[8] = attp_pkg::mul_br(bb[3], root[2]);
		ax_c[8] = attp_pkg::c256(cc[4]);

		sc_c[0] = root[0];
		sc_c[1] = root[1];
		sc_c[2] = ab22[RW-1:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ay_s4 <= ay_c;
			ax_s4 <= ax_c;
			sc_s4 <= sc_c;
		end
	end

	// ---------------- atan2 ----------------
	logic signed [AW-1:0] ang [9];
	logic [2:0][RW-1:0]   sc_dly_q [CL];

	generate
		for (g = 0; g < 9; g++) begin : g_cordic
			attp_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
				.clk   (clk),
				.en    (en),
				.y_in  (ay_s4[g]),
				.x_in  (ax_s4[g]),
				.z_out (ang[g])
			);
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 3; a++) begin
				sc_dly_q[0][a] <= sc_s4[a];
			end
			for (int i = 1; i < CL; i++) begin
				sc_dly_q[i] <= sc_dly_q[i-1];
			end
		end
	end

	// ---------------- s5: tilt limit and clamp ----------------
	logic signed [EW-1:0] e1_c [3];
	logic signed [EW-1:0] e2_c [3];
	logic signed [EW-1:0] tl_c [3];
	logic signed [EW-1:0] e1_s5 [3];
	logic signed [EW-1:0] e2_s5 [3];
	logic signed [EW-1:0] tl_s5 [3];
	logic [RW-1:0]        sc_s5 [3];

	always_comb begin
		logic signed [AW-1:0] tz;
		logic signed [AW-1:0] ez1;
		logic signed [AW-1:0] ez2;
		for (int a = 0; a < 3; a++) begin
			tz  = (ang[3*a] < 0) ? '0 : (ang[3*a] >>> 1);
			ez1 = NEG1[a] ? -ang[3*a+1] : ang[3*a+1];
			ez2 = NEG2[a] ? -ang[3*a+2] : ang[3*a+2];
			if (ez1 > tz) begin
				ez1 = tz;
			end else if (ez1 < -tz) begin
				ez1 = -tz;
			end
			if (ez2 > tz) begin
				ez2 = tz;
			end else if (ez2 < -tz) begin
				ez2 = -tz;
			end
			tl_c[a] = EW'(tz);
			e1_c[a] = EW'(ez1);
			e2_c[a] = EW'(ez2);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e1_s5 <= e1_c;
			e2_s5 <= e2_c;
			tl_s5 <= tl_c;
			for (int a = 0; a < 3; a++) begin
				sc_s5[a] <= sc_dly_q[CL-1][a];
			end
		end
	end

	// ---------------- s6..s10: torque ----------------
	logic [CFGW-1:0]       ia [3];
	logic [CFGW-1:0]       ib [3];
	logic signed [MW-1:0]  m1_s6 [3];
	logic signed [MW-1:0]  m2_s6 [3];
	logic [RW-1:0]         sc_s6 [3];
	logic signed [SMW-1:0] sm_s7 [3];
	logic [RW-1:0]         sc_s7 [3];
	logic signed [SW-1:0]  s_s8 [3];
	logic [RW-1:0]         sc_s8 [3];
	logic signed [PPW-1:0] phi_s9 [3];
	logic signed [PPW-1:0] plo_s9 [3];
	logic signed [31:0]    out_s10 [3];

	assign ia[0] = inertia_y_q;
	assign ib[0] = inertia_z_q;
	assign ia[1] = inertia_x_q;
	assign ib[1] = inertia_z_q;
	assign ia[2] = inertia_x_q;
	assign ib[2] = inertia_y_q;

	always_ff @(posedge clk) begin
		logic signed [SW-1:0] sh12;
		logic signed [TW-1:0] t;
		logic signed [TW-1:0] ts;
		if (en) begin
			for (int a = 0; a < 3; a++) begin
				m1_s6[a] <= MW'(e1_s5[a]) * $signed({{(MW-CFGW){1'b0}}, ia[a]});
				m2_s6[a] <= MW'(e2_s5[a]) * $signed({{(MW-CFGW){1'b0}}, ib[a]});
				sc_s6[a] <= sc_s5[a];

				sm_s7[a] <= SMW'(m1_s6[a]) + SMW'(m2_s6[a]);
				sc_s7[a] <= sc_s6[a];

				s_s8[a]  <= SW'(sm_s7[a]) * $signed({{(SW-CFGW){1'b0}}, gain_q});
				sc_s8[a] <= sc_s7[a];

				sh12       = s_s8[a] >>> 12;
				phi_s9[a] <= PPW'(sh12) *
					$signed({{(PPW-HALF){1'b0}}, sc_s8[a][RW-1:HALF]});
				plo_s9[a] <= PPW'(sh12) *
					$signed({{(PPW-HALF){1'b0}}, sc_s8[a][HALF-1:0]});

				t  = (TW'(phi_s9[a]) <<< HALF) + TW'(plo_s9[a]);
				ts = t >>> 26;
				if ((&ts[TW-1:31]) || !(|ts[TW-1:31])) begin
					out_s10[a] <= ts[31:0];
				end else if (ts[TW-1]) begin
					out_s10[a] <= 32'sh8000_0000;
				end else begin
					out_s10[a] <= 32'sh7fff_ffff;
				end
			end
		end
	end

	assign torque_roll  = out_s10[0];
	assign torque_pitch = out_s10[1];
	assign torque_yaw   = out_s10[2];

	// ---------------- assertions ----------------
	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |-> in_stall)
		else $error("pipeline advanced while output stalled");

	a_valid_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q))
		else $error("valid chain moved while pipeline held");

	a_clamp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[CLAMP_IDX] |->
			(e1_s5[0] <= tl_s5[0]) && (e1_s5[0] >= -tl_s5[0]) &&
			(e2_s5[0] <= tl_s5[0]) && (e2_s5[0] >= -tl_s5[0]) &&
			(e1_s5[1] <= tl_s5[1]) && (e1_s5[1] >= -tl_s5[1]) &&
			(e2_s5[1] <= tl_s5[1]) && (e2_s5[1] >= -tl_s5[1]) &&
			(e1_s5[2] <= tl_s5[2]) && (e1_s5[2] >= -tl_s5[2]) &&
			(e2_s5[2] <= tl_s5[2]) && (e2_s5[2] >= -tl_s5[2]))
		else $error("error angle outside tilt limit");

endmodule

### src/attp_sqrt.sv
// ----------------------------------------------------------------------------
// attp_sqrt
// Pipelined integer square root, one result bit per stage, floor result.
// ----------------------------------------------------------------------------
module attp_sqrt (
	input  logic                          clk,
	input  logic                          en,
	input  logic [attp_pkg::SQW-1:0]      v_in,
	output logic [attp_pkg::RW-1:0]       root
);

	localparam int N = attp_pkg::RW;
	localparam int W = attp_pkg::SQW;

	logic [W-1:0] v_s [N];
	logic [W-1:0] r_s [N];

	genvar k;
	generate
		for (k = 0; k < N; k++) begin : g_stage
			logic [W-1:0] vp;
			logic [W-1:0] rp;
			logic [W-1:0] bitv;
			logic [W-1:0] trial;

			if (k == 0) begin : g_first
				assign vp = v_in;
				assign rp = '0;
			end else begin : g_next
				assign vp = v_s[k-1];
				assign rp = r_s[k-1];
			end

			assign bitv  = W'(1) << (W - 2 - 2 * k);
			assign trial = rp + bitv;

			always_ff @(posedge clk) begin
				if (en) begin
					if (vp >= trial) begin
						v_s[k] <= vp - trial;
						r_s[k] <= (rp >> 1) + bitv;
					end else begin
						v_s[k] <= vp;
						r_s[k] <= rp >> 1;
					end
				end
			end
		end
	endgenerate

	assign root = r_s[N-1][N-1:0];

endmodule

### src/attp_cordic.sv
// ----------------------------------------------------------------------------
// attp_cordic
// Pipelined vectoring CORDIC atan2(y, x): one quadrant stage, then one
// micro-rotation per stage.
// ----------------------------------------------------------------------------
module attp_cordic #(
	parameter int STEPS = 16
) (
	input  logic                                clk,
	input  logic                                en,
	input  logic signed [attp_pkg::CW-1:0]      y_in,
	input  logic signed [attp_pkg::CW-1:0]      x_in,
	output logic signed [attp_pkg::AW-1:0]      z_out
);

	localparam int CW = attp_pkg::CW;
	localparam int AW = attp_pkg::AW;

	logic signed [CW-1:0] x_s [STEPS+1];
	logic signed [CW-1:0] y_s [STEPS+1];
	logic signed [AW-1:0] z_s [STEPS+1];
	logic                 zero_s [STEPS+1];

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s[0] <= (x_in == '0) && (y_in == '0);
			if (x_in < 0) begin
				x_s[0] <= -x_in;
				y_s[0] <= -y_in;
				z_s[0] <= (y_in >= 0) ? attp_pkg::ANG_PI : -attp_pkg::ANG_PI;
			end else begin
				x_s[0] <= x_in;
				y_s[0] <= y_in;
				z_s[0] <= '0;
			end
		end
	end

	genvar k;
	generate
		for (k = 0; k < STEPS; k++) begin : g_step
			logic signed [CW-1:0] xs;
			logic signed [CW-1:0] ys;
			assign xs = x_s[k] >>> k;
			assign ys = y_s[k] >>> k;

			always_ff @(posedge clk) begin
				if (en) begin
					zero_s[k+1] <= zero_s[k];
					if (y_s[k] >= 0) begin
						x_s[k+1] <= x_s[k] + ys;
						y_s[k+1] <= y_s[k] - xs;
						z_s[k+1] <= z_s[k] + attp_pkg::atan_entry(k);
					end else begin
						x_s[k+1] <= x_s[k] - ys;
						y_s[k+1] <= y_s[k] + xs;
						z_s[k+1] <= z_s[k] - attp_pkg::atan_entry(k);
					end
				end
			end
		end
	endgenerate

	assign z_out = zero_s[STEPS] ? '0 : z_s[STEPS];

endmodule
